@@ hw/rtl/nta_pkg.sv @@
// Shared constants, payload types and control types of the neighbor table.
`default_nettype none
package nta_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W      = 8;
	localparam int MISS_W      = 4;
	localparam int OUT_CNT_W   = 5;

	localparam logic [MISS_W-1:0] MISS_LIMIT_RESET = MISS_W'(3);
	localparam logic [MISS_W-1:0] MISSES_MAX       = '1;

	localparam logic CMD_BEACON = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [ADDR_W-1:0] heard_address;
	} nta_in_t;

	typedef struct packed {
		logic [OUT_CNT_W-1:0] neighbor_count;
		logic                 was_known;
		logic                 was_added;
		logic                 dropped_full;
		logic [OUT_CNT_W-1:0] removed_count;
	} nta_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} nta_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} nta_cmd_t;

	typedef struct packed {
		logic at_end;
		logic hit;
	} nta_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/neighbor_table_aging.sv @@
// Neighbor table with aging miss counters: top level.
//
// Input channel (in_valid/in_ready/in_data): one item is either a beacon
// (cmd 0, heard_address looked up and refreshed or appended) or an aging
// tick (cmd 1, expired entries removed, survivors compacted and aged).
// Output channel (out_valid/out_ready/out_data): exactly one result per item.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes miss_limit, always
// ready; write only while no item is in flight.
// Timing: the controller scans the table one entry per cycle. One item is in the
// block at a time and the next is accepted in the cycle after the result is loaded.
// A new item is taken while the previous result still waits in the output register.
// Reset: table empty, miss_limit = 3, no result pending. Table contents are
// not cleared, only the entry count.
// Stall: if out_ready stays low, the next item finishes its scan and holds
// until the output register frees up.
`default_nettype none
module neighbor_table_aging import nta_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire nta_in_t           in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output nta_out_t               out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [MISS_W-1:0] cfg_data
);

	nta_cmd_t    ctl;
	nta_status_t sts;

	assign cfg_ready = 1'b1;

	nta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	nta_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.ctl      (ctl),
		.sts      (sts),
		.out_data (out_data)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in progress");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({out_data.was_known, out_data.was_added,
			out_data.dropped_full}) <= 1)
		else $error("more than one beacon flag set");

	a_removed_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.removed_count != '0) |->
			!out_data.was_known && !out_data.was_added && !out_data.dropped_full)
		else $error("removal reported together with beacon flags");

	a_result_follows_finish: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |=> out_valid)
		else $error("finished item did not raise out_valid");

endmodule
`default_nettype wire

@@ hw/rtl/nta_datapath.sv @@
// Table storage, scan counters, lookup and compaction logic, result register.
`default_nettype none
module nta_datapath import nta_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire nta_in_t           in_data,
	input  wire logic              cfg_wr,
	input  wire logic [MISS_W-1:0] cfg_data,
	input  wire nta_cmd_t          ctl,
	output nta_status_t            sts,
	output nta_out_t               out_data
);

	logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
	logic [MISS_W-1:0] miss_mem [TABLE_DEPTH];

	logic [MISS_W-1:0] miss_limit_q;
	logic              cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  k_q;
	logic [CNT_W-1:0]  keep_q;
	logic [CNT_W-1:0]  gone_q;
	logic [CNT_W-1:0]  count_q;
	logic              known_q;
	nta_out_t          out_q;

	logic [IDX_W-1:0]  rd_idx;
	logic [ADDR_W-1:0] rd_addr;
	logic [MISS_W-1:0] rd_miss;
	logic              expired;
	logic [MISS_W-1:0] miss_inc;
	logic              has_room;
	logic              we;
	logic [IDX_W-1:0]  wr_idx;
	logic [ADDR_W-1:0] wr_addr;
	logic [MISS_W-1:0] wr_miss;
	logic [CNT_W-1:0]  new_count;

	assign rd_idx   = k_q[IDX_W-1:0];
	assign rd_addr  = addr_mem[rd_idx];
	assign rd_miss  = miss_mem[rd_idx];
	assign expired  = rd_miss > miss_limit_q;
	assign miss_inc = (rd_miss == MISSES_MAX) ? MISSES_MAX : rd_miss + MISS_W'(1);
	assign has_room = count_q < CNT_W'(TABLE_DEPTH);

	assign sts.at_end = k_q == count_q;
	assign sts.hit    = (cmd_q == CMD_BEACON) && (rd_addr == addr_q);

	always_comb begin
		we      = 1'b0;
		wr_idx  = rd_idx;
		wr_addr = rd_addr;
		wr_miss = '0;
		if (ctl.step) begin
			if (cmd_q == CMD_TICK) begin
				we      = !expired;
				wr_idx  = keep_q[IDX_W-1:0];
				wr_miss = miss_inc;
			end else begin
				we = sts.hit;
			end
		end else if (ctl.finish) begin
			we      = (cmd_q == CMD_BEACON) && !known_q && has_room;
			wr_idx  = count_q[IDX_W-1:0];
			wr_addr = addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			addr_mem[wr_idx] <= wr_addr;
			miss_mem[wr_idx] <= wr_miss;
		end
	end

	always_comb begin
		if (cmd_q == CMD_TICK) begin
			new_count = keep_q;
		end else if (!known_q && has_room) begin
			new_count = count_q + CNT_W'(1);
		end else begin
			new_count = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_limit_q <= MISS_LIMIT_RESET;
			count_q      <= '0;
		end else begin
			if (cfg_wr) begin
				miss_limit_q <= cfg_data;
			end
			if (ctl.finish) begin
				count_q <= new_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= in_data.cmd;
			addr_q  <= in_data.heard_address;
			k_q     <= '0;
			keep_q  <= '0;
			gone_q  <= '0;
			known_q <= 1'b0;
		end else if (ctl.step) begin
			k_q <= k_q + CNT_W'(1);
			if (cmd_q == CMD_TICK) begin
				if (expired) begin
					gone_q <= gone_q + CNT_W'(1);
				end else begin
					keep_q <= keep_q + CNT_W'(1);
				end
			end else if (sts.hit) begin
				known_q <= 1'b1;
			end
		end
		if (ctl.finish) begin
			out_q.neighbor_count <= OUT_CNT_W'(new_count);
			out_q.was_known      <= (cmd_q == CMD_BEACON) && known_q;
			out_q.was_added      <= (cmd_q == CMD_BEACON) && !known_q && has_room;
			out_q.dropped_full   <= (cmd_q == CMD_BEACON) && !known_q && !has_room;
			out_q.removed_count  <= (cmd_q == CMD_TICK) ? OUT_CNT_W'(gone_q) : '0;
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

@@ hw/rtl/nta_ctrl.sv @@
// Sequencing state machine: accepts an item, runs the table scan, hands off the result.
`default_nettype none
module nta_ctrl import nta_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire nta_status_t sts,
	output nta_cmd_t         ctl
);

	nta_state_t state_q;
	nta_state_t state_d;
	logic       out_valid_q;
	logic       out_valid_d;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.at_end || sts.hit) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		ctl.load   = 1'b0;
		ctl.step   = 1'b0;
		ctl.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.load = in_valid;
			end
			ST_SCAN: begin
				ctl.step = !sts.at_end;
			end
			ST_FINISH: begin
				ctl.finish = slot_free;
			end
			default: ;
		endcase
		if (ctl.finish) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
